/* rtl/core/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Entry layout, control group and action codes shared by the queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PID_W   = 22;
    localparam int PRIO_W  = 8;
    localparam int KEY_W   = 16;
    localparam int COUNT_W = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
        logic [PID_W-1:0]  pid;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

/* rtl/core/spq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on an insert it keeps, shifts in from the left or takes the
// new entry, and on a pop it shifts in from the right.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_left_entry,
    input  logic                i_left_valid,
    input  logic                i_left_gt,
    input  spq_pkg::t_entry     i_right_entry,
    input  logic                i_right_valid,
    output spq_pkg::t_entry     o_entry,
    output logic                o_valid,
    output logic                o_gt,
    output spq_pkg::t_entry     o_next_entry,
    output logic                o_next_valid
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;
    logic   w_gt;

    // An empty cell counts as holding a larger key, so the flags along the row
    // change from low to high at most once.
    assign w_gt = !r_valid || (r_entry.key > i_new.key);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.ins && w_gt) begin
            if (i_left_gt) begin
                n_entry = i_left_entry;
                n_valid = i_left_valid;
            end else begin
                n_entry = i_new;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry      = r_entry;
    assign o_valid      = r_valid;
    assign o_gt         = w_gt;
    assign o_next_entry = n_entry;
    assign o_next_valid = n_valid;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue
// Up to ENTRIES scheduler entries kept in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// The input channel carries one command per transaction: tuser selects insert
// or pop, tdata carries the entry to insert. Every command returns exactly one
// transaction on the output channel with the popped entry, the dropped flag,
// the head entry, the empty flag and the entry count after the command.
// The row of cells updates in the same edge that accepts a command, each cell
// comparing its key with the new key in parallel, and the result is held in
// an output register, which presents the result in the cycle after acceptance;
// a new command is taken every cycle in which the output register is empty
// or being drained, so throughput is one command per cycle with a ready
// receiver. When the receiver stalls, the result stays put and the input is
// held off until it is taken. Reset empties the queue and discards any
// pending result; no clearing pass is needed. Inserts into a full queue
// are dropped and flagged; pops from an empty queue change nothing.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pid[21:0], priority[29:22], key[45:30], zero pad[47:46]
    input  logic [47:0] s_axis_tdata,
    // action[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // popped_valid[0], popped_pid[22:1], popped_priority[30:23],
    // popped_key[46:31], insert_dropped[47], queue_empty[48],
    // head_pid[70:49], head_key[86:71], entry_count[91:87], zero pad[95:92]
    output logic [95:0] m_axis_tdata
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int OUT_W = 1 + PID_W + PRIO_W + KEY_W + 1 + 1 + PID_W + KEY_W + COUNT_W;

    t_entry     w_entry      [ENTRIES];
    logic       w_valid      [ENTRIES];
    logic       w_gt         [ENTRIES];
    t_entry     w_next_entry [ENTRIES];
    logic       w_next_valid [ENTRIES];
    logic [ENTRIES-1:0] w_valid_vec;

    t_entry     w_new;
    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W+4:0]   w_count_ext;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [OUT_W-1:0]   r_out;
    logic [OUT_W-1:0]   n_out;

    logic               w_pop_valid;
    t_entry             w_popped;
    t_entry             w_head;

    assign w_new.pid  = s_axis_tdata[PID_W-1:0];
    assign w_new.prio = s_axis_tdata[PID_W+PRIO_W-1:PID_W];
    assign w_new.key  = s_axis_tdata[PID_W+PRIO_W+KEY_W-1:PID_W+PRIO_W];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(ENTRIES));
    assign w_empty       = (r_count == '0);

    assign w_ctrl.ins = w_accept && (s_axis_tuser == ACT_INSERT) && !w_full;
    assign w_ctrl.pop = w_accept && (s_axis_tuser == ACT_POP) && !w_empty;

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        t_entry w_left_entry;
        logic   w_left_valid;
        logic   w_left_gt;
        t_entry w_right_entry;
        logic   w_right_valid;

        if (gi == 0) begin : g_first
            assign w_left_entry = '0;
            assign w_left_valid = 1'b0;
            assign w_left_gt    = 1'b0;
        end else begin : g_mid_left
            assign w_left_entry = w_entry[gi-1];
            assign w_left_valid = w_valid[gi-1];
            assign w_left_gt    = w_gt[gi-1];
        end

        if (gi == ENTRIES - 1) begin : g_last
            assign w_right_entry = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_right
            assign w_right_entry = w_entry[gi+1];
            assign w_right_valid = w_valid[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new         (w_new),
            .i_left_entry  (w_left_entry),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_right_entry (w_right_entry),
            .i_right_valid (w_right_valid),
            .o_entry       (w_entry[gi]),
            .o_valid       (w_valid[gi]),
            .o_gt          (w_gt[gi]),
            .o_next_entry  (w_next_entry[gi]),
            .o_next_valid  (w_next_valid[gi])
        );

        assign w_valid_vec[gi] = w_valid[gi];
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_ext = {5'd0, n_count};
    assign w_pop_valid = w_ctrl.pop;
    assign w_popped    = w_pop_valid ? w_entry[0] : '0;
    assign w_head      = w_next_valid[0] ? w_next_entry[0] : '0;

    always_comb begin
        n_out = {w_count_ext[COUNT_W-1:0],
                 w_head.key,
                 w_head.pid,
                 !w_next_valid[0],
                 w_accept && (s_axis_tuser == ACT_INSERT) && w_full,
                 w_popped.key,
                 w_popped.prio,
                 w_popped.pid,
                 w_pop_valid};
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(96 - OUT_W){1'b0}}, r_out};

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count exceeds queue depth");

    a_valid_matches_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_head_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[0] && w_valid[1]) |-> (w_entry[0].key <= w_entry[1].key))
        else $error("head entries out of key order");

    a_pop_decrements : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not reduce entry count");

    a_drop_only_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_axis_tuser == ACT_INSERT)) |=> (r_out[47] == $past(w_full)))
        else $error("insert dropped flag inconsistent with full queue");

endmodule
